/* hdl/spi_parity_read_master_assert.svh */
// Assertion macros for the SPI parity read master.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SPI_PARITY_READ_MASTER_ASSERT_SVH
`define SPI_PARITY_READ_MASTER_ASSERT_SVH

// Same-cycle implication.
`define SPM_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/spm_pkg.sv */
// Package for the SPI parity read master: phase type, register map and reset values.
// Used by spi_parity_read_master, its checker and its testbench; depends on nothing.
package spm_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CMD  = 2'd1,
        PH_RESP = 2'd2
    } t_phase;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int HALF_W          = 16;
    localparam int ATT_W           = 4;
    localparam int BYTE_W          = 8;
    localparam int BIT_IDX_W       = 5;
    localparam int APB_ADDR_W      = 4;

    localparam logic [BIT_IDX_W-1:0] CMD_BITS  = BIT_IDX_W'(2 * BYTE_W);
    localparam logic [BIT_IDX_W-1:0] RESP_BITS = BIT_IDX_W'(BYTE_W);

    localparam logic [HALF_W-1:0] HALF_PERIOD_RST  = 16'd50;
    localparam logic [ATT_W-1:0]  MAX_ATTEMPTS_RST = 4'd5;
    localparam logic [BYTE_W-1:0] COMMAND_CODE_RST = 8'hAA;

    localparam logic [APB_ADDR_W-1:0] REG_HALF_PERIOD  = 4'h0;
    localparam logic [APB_ADDR_W-1:0] REG_MAX_ATTEMPTS = 4'h4;
    localparam logic [APB_ADDR_W-1:0] REG_COMMAND_CODE = 4'h8;

endpackage

/* hdl/spi_parity_read_master.sv */
// SPI master that reads one byte per request, checks even parity and retries.
// Depends on spm_pkg and on the assertion macros in spi_parity_read_master_assert.svh.
//
// Every input item is one system clock tick of the SPI timing, and every item gives
// exactly one result item with the pin levels and status of that tick. The block takes
// one item per clock cycle and hands its result out in the next cycle through an output
// register; a stalled output stops intake only while that register is still full.
// One transaction sends 16 command bits and receives 8 response bits, and a read makes
// up to max_attempts transactions.
module spi_parity_read_master #(
    parameter int TIMER_WIDTH = spm_pkg::TIMER_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] address, [8] miso, [15:9] zero
    input  logic [15:0]                   s_axis_tdata,
    // [0] req_type
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] sclk, [1] mosi, [2] busy_res, [3] done_res, [10:4] read_data,
    // [11] parity_ok, [15:12] attempts_used
    output logic [15:0]                   m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import spm_pkg::*;

    logic [HALF_W-1:0]      r_half_period;
    logic [ATT_W-1:0]       r_max_attempts;
    logic [BYTE_W-1:0]      r_command_code;

    t_phase                 r_phase, n_phase;
    logic [BIT_IDX_W-1:0]   r_bit_index, n_bit_index;
    logic [TIMER_WIDTH-1:0] r_tick_count, n_tick_count;
    logic                   r_clk_level, n_clk_level;
    logic [2*BYTE_W-1:0]    r_tx_shift, n_tx_shift;
    logic [BYTE_W-1:0]      r_rx_shift, n_rx_shift;
    logic [ATT_W-1:0]       r_attempt_count, n_attempt_count;
    logic [BYTE_W-1:0]      r_held_address, n_held_address;

    logic                   r_m_tvalid;
    logic [15:0]            r_m_tdata, n_m_tdata;

    logic [TIMER_WIDTH-1:0] w_half_sat, w_half_eff;
    logic [ATT_W-1:0]       w_limit;
    logic                   w_accept, w_cfg_wr, w_done;

    assign pready        = 1'b1;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign s_axis_tready = i_rst_n && (!r_m_tvalid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    if (TIMER_WIDTH >= HALF_W) begin : g_timer_wide
        assign w_half_sat = TIMER_WIDTH'(r_half_period);
    end else begin : g_timer_narrow
        assign w_half_sat = (|r_half_period[HALF_W-1:TIMER_WIDTH]) ? '1
                                                                   : r_half_period[TIMER_WIDTH-1:0];
    end
    assign w_half_eff = (w_half_sat == '0) ? TIMER_WIDTH'(1) : w_half_sat;
    assign w_limit    = (r_max_attempts == '0) ? ATT_W'(1) : r_max_attempts;

    always_comb begin
        case (paddr)
            REG_HALF_PERIOD:  prdata = 32'(r_half_period);
            REG_MAX_ATTEMPTS: prdata = 32'(r_max_attempts);
            REG_COMMAND_CODE: prdata = 32'(r_command_code);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        logic                   v_sclk, v_mosi, v_busy, v_ok, v_pok;
        logic [6:0]             v_data;
        logic [ATT_W-1:0]       v_used;
        logic [3:0]             v_tx_idx;

        n_phase         = r_phase;
        n_bit_index     = r_bit_index;
        n_tick_count    = r_tick_count;
        n_clk_level     = r_clk_level;
        n_tx_shift      = r_tx_shift;
        n_rx_shift      = r_rx_shift;
        n_attempt_count = r_attempt_count;
        n_held_address  = r_held_address;
        v_sclk          = 1'b0;
        v_mosi          = 1'b0;
        v_busy          = 1'b0;
        v_ok            = 1'b0;
        v_pok           = 1'b0;
        v_data          = '0;
        v_used          = '0;
        v_tx_idx        = '0;
        w_done          = 1'b0;

        if (n_phase != PH_CMD && n_phase != PH_RESP) begin
            n_phase = PH_IDLE;
            if (s_axis_tuser[0]) begin
                n_held_address  = s_axis_tdata[BYTE_W-1:0];
                n_tx_shift      = {r_command_code, n_held_address};
                n_attempt_count = ATT_W'(1);
                n_phase         = PH_CMD;
                n_bit_index     = '0;
                n_tick_count    = '0;
                n_clk_level     = 1'b1;
                n_rx_shift      = '0;
            end
        end

        if (n_phase != PH_IDLE) begin
            v_busy = 1'b1;
            v_sclk = n_clk_level;
            v_used = n_attempt_count;
            if (n_phase == PH_CMD) begin
                v_tx_idx = 4'(CMD_BITS - 1) - n_bit_index[3:0];
                v_mosi   = n_tx_shift[v_tx_idx];
            end else if (n_clk_level && n_tick_count == '0) begin
                n_rx_shift = {n_rx_shift[BYTE_W-2:0], s_axis_tdata[BYTE_W]};
            end

            n_tick_count = n_tick_count + TIMER_WIDTH'(1);
            if (n_tick_count >= w_half_eff) begin
                n_tick_count = '0;
                if (n_clk_level) begin
                    n_clk_level = 1'b0;
                end else begin
                    n_clk_level = 1'b1;
                    n_bit_index = n_bit_index + BIT_IDX_W'(1);
                    if (n_phase == PH_CMD && n_bit_index >= CMD_BITS) begin
                        n_phase     = PH_RESP;
                        n_bit_index = '0;
                        n_rx_shift  = '0;
                    end else if (n_phase == PH_RESP && n_bit_index >= RESP_BITS) begin
                        v_ok = ~^n_rx_shift;
                        if (v_ok || n_attempt_count >= w_limit) begin
                            w_done      = 1'b1;
                            v_data      = n_rx_shift[BYTE_W-1:1];
                            v_pok       = v_ok;
                            n_phase     = PH_IDLE;
                            n_bit_index = '0;
                            n_clk_level = 1'b0;
                        end else begin
                            n_attempt_count = n_attempt_count + ATT_W'(1);
                            n_phase         = PH_CMD;
                            n_bit_index     = '0;
                            n_tick_count    = '0;
                            n_clk_level     = 1'b1;
                            n_rx_shift      = '0;
                        end
                    end
                end
            end
        end

        n_m_tdata = {v_used, v_pok, v_data, w_done, v_busy, v_mosi, v_sclk};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period   <= HALF_PERIOD_RST;
            r_max_attempts  <= MAX_ATTEMPTS_RST;
            r_command_code  <= COMMAND_CODE_RST;
            r_phase         <= PH_IDLE;
            r_bit_index     <= '0;
            r_tick_count    <= '0;
            r_clk_level     <= 1'b0;
            r_tx_shift      <= '0;
            r_rx_shift      <= '0;
            r_attempt_count <= '0;
            r_held_address  <= '0;
            r_m_tvalid      <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr)
                    REG_HALF_PERIOD:  r_half_period  <= pwdata[HALF_W-1:0];
                    REG_MAX_ATTEMPTS: r_max_attempts <= pwdata[ATT_W-1:0];
                    REG_COMMAND_CODE: r_command_code <= pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_phase         <= n_phase;
                r_bit_index     <= n_bit_index;
                r_tick_count    <= n_tick_count;
                r_clk_level     <= n_clk_level;
                r_tx_shift      <= n_tx_shift;
                r_rx_shift      <= n_rx_shift;
                r_attempt_count <= n_attempt_count;
                r_held_address  <= n_held_address;
                r_m_tvalid      <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_tdata <= n_m_tdata;
        end
    end

`include "spi_parity_read_master_assert.svh"

    `SPM_ASSERT_SAME(a_idle_quiet, r_phase == PH_IDLE, !r_clk_level && r_bit_index == '0, "Idle not quiet.")
    `SPM_ASSERT_SAME(a_attempt_nonzero, r_phase != PH_IDLE, r_attempt_count != '0, "No attempt counted.")
    `SPM_ASSERT_NEXT(a_done_to_idle, w_accept && w_done, r_phase == PH_IDLE && r_m_tvalid && r_m_tdata[3], "Bad done.")

endmodule

/* sim/spi_parity_read_master_checker.sv */
// Checker for the SPI parity read master: predicts the pin levels and status of every tick
// from the accepted input items and the APB writes, and compares them with the result stream.
// Depends on spm_pkg; hands its failure count and the number of outstanding ticks to the top.
module spi_parity_read_master_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [15:0]                    i_s_tdata,
    input  logic [0:0]                     i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [15:0]                    i_m_tdata,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [spm_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [31:0]                    i_pwdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    typedef struct packed {
        logic [3:0] used;
        logic       pok;
        logic [6:0] data;
        logic       done;
        logic       busy;
        logic       mosi;
        logic       sclk;
    } t_spi_tick;

    logic [HALF_W-1:0]          half_period_q;
    logic [ATT_W-1:0]           max_att_q;
    logic [BYTE_W-1:0]          cmd_q;
    t_phase                     xfer_phase;
    logic [BIT_IDX_W-1:0]       bit_idx;
    logic [TIMER_WIDTH_DEF-1:0] tick_cnt;
    logic                       sclk_lvl;
    logic [15:0]                tx_sr;
    logic [7:0]                 rx_sr;
    logic [ATT_W-1:0]           attempt_no;
    logic [7:0]                 held_addr;

    t_spi_tick pins_due[$];
    int        errors = 0;
    int        due_count = 0;

    assign o_fail_count = errors;
    assign o_pending    = due_count;

    task automatic report(input string msg);
        errors++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [6:0] got, input logic [6:0] want);
        if (got !== want) begin
            report($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic begin_xfer();
        xfer_phase = PH_CMD;
        bit_idx    = '0;
        tick_cnt   = '0;
        sclk_lvl   = 1'b1;
        rx_sr      = '0;
    endtask

    task automatic predict_tick(input logic req, input logic [7:0] addr, input logic miso,
                                output t_spi_tick pins);
        logic [TIMER_WIDTH_DEF-1:0] half_eff;
        logic [ATT_W-1:0]           att_limit;
        logic [3:0]                 tx_pos;
        logic                       rising;
        logic                       even;
        pins      = '0;
        half_eff  = (half_period_q == '0) ? TIMER_WIDTH_DEF'(1) : half_period_q;
        att_limit = (max_att_q == '0) ? ATT_W'(1) : max_att_q;
        if (xfer_phase != PH_CMD && xfer_phase != PH_RESP) begin
            xfer_phase = PH_IDLE;
            if (req) begin
                held_addr  = addr;
                tx_sr      = {cmd_q, addr};
                attempt_no = ATT_W'(1);
                begin_xfer();
            end
        end
        if (xfer_phase != PH_IDLE) begin
            rising    = sclk_lvl && (tick_cnt == '0);
            pins.busy = 1'b1;
            pins.sclk = sclk_lvl;
            pins.used = attempt_no;
            if (xfer_phase == PH_CMD) begin
                tx_pos    = 4'(CMD_BITS - 5'd1 - bit_idx);
                pins.mosi = tx_sr[tx_pos];
            end else if (rising) begin
                rx_sr = {rx_sr[6:0], miso};
            end
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= half_eff) begin
                tick_cnt = '0;
                if (sclk_lvl) begin
                    sclk_lvl = 1'b0;
                end else begin
                    sclk_lvl = 1'b1;
                    bit_idx  = bit_idx + 1'b1;
                    if (xfer_phase == PH_CMD && bit_idx >= CMD_BITS) begin
                        xfer_phase = PH_RESP;
                        bit_idx    = '0;
                        rx_sr      = '0;
                    end else if (xfer_phase == PH_RESP && bit_idx >= RESP_BITS) begin
                        even = ~^rx_sr;
                        if (even || attempt_no >= att_limit) begin
                            pins.done  = 1'b1;
                            pins.data  = rx_sr[7:1];
                            pins.pok   = even;
                            xfer_phase = PH_IDLE;
                            bit_idx    = '0;
                            sclk_lvl   = 1'b0;
                        end else begin
                            attempt_no = attempt_no + 1'b1;
                            begin_xfer();
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_spi_tick pins;
        t_spi_tick want;
        t_spi_tick seen;
        if (!i_rst_n) begin
            half_period_q = HALF_PERIOD_RST;
            max_att_q     = MAX_ATTEMPTS_RST;
            cmd_q         = COMMAND_CODE_RST;
            xfer_phase    = PH_IDLE;
            bit_idx       = '0;
            tick_cnt      = '0;
            sclk_lvl      = 1'b0;
            tx_sr         = '0;
            rx_sr         = '0;
            attempt_no    = '0;
            held_addr     = '0;
            pins_due.delete();
            due_count     = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    REG_HALF_PERIOD:  half_period_q = i_pwdata[HALF_W-1:0];
                    REG_MAX_ATTEMPTS: max_att_q     = i_pwdata[ATT_W-1:0];
                    REG_COMMAND_CODE: cmd_q         = i_pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_tick(i_s_tuser[0], i_s_tdata[7:0], i_s_tdata[8], pins);
                pins_due.push_back(pins);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pins_due.size() == 0) begin
                    report("result item arrived with no input item outstanding");
                end else begin
                    want = pins_due.pop_front();
                    seen = i_m_tdata;
                    check_field("sclk", 7'(seen.sclk), 7'(want.sclk));
                    check_field("mosi", 7'(seen.mosi), 7'(want.mosi));
                    check_field("busy", 7'(seen.busy), 7'(want.busy));
                    check_field("done", 7'(seen.done), 7'(want.done));
                    check_field("read_data", seen.data, want.data);
                    check_field("parity_ok", 7'(seen.pok), 7'(want.pok));
                    check_field("attempts_used", 7'(seen.used), 7'(want.used));
                end
            end
            due_count = pins_due.size();
        end
    end

endmodule

/* sim/spi_parity_read_master_test.sv */
// Top of the SPI parity read master testbench: clock, reset, APB programming and tick stimulus.
// Depends on spm_pkg, spi_parity_read_master and spi_parity_read_master_checker.
module spi_parity_read_master_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int         fail_count;
    int         pending;
    int         sent = 0;
    int         idle_cycles = 0;
    bit         gap_on = 1'b1;
    int         cur_half = int'(HALF_PERIOD_RST);
    int         cur_max = int'(MAX_ATTEMPTS_RST);
    logic [7:0] byte_plan[$];
    int         calm_left = 0;
    int         stall_left = 0;
    int         roll;

    spi_parity_read_master dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    spi_parity_read_master_checker pin_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(negedge i_clk) begin
        if (calm_left > 0) begin
            calm_left--;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            roll = $urandom_range(0, 199);
            if (roll == 0) begin
                calm_left = $urandom_range(50, 300);
                m_axis_tready <= 1'b1;
            end else if (roll < 140) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left = (roll < 190) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] byte_with_parity(input bit odd);
        logic [7:0] b;
        int         pos;
        b = 8'($urandom);
        if ((^b) != odd) begin
            pos    = $urandom_range(0, 7);
            b[pos] = ~b[pos];
        end
        return b;
    endfunction

    task automatic send_tick(input bit req, input logic [7:0] addr, input bit miso);
        int gap;
        gap = gap_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, miso, addr};
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic wait_all_ticks_back();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_spi(input logic [15:0] half, input logic [3:0] att,
                               input logic [7:0] cmd);
        wait_all_ticks_back();
        apb_write(REG_HALF_PERIOD, {16'd0, half});
        apb_write(REG_MAX_ATTEMPTS, {28'd0, att});
        apb_write(REG_COMMAND_CODE, {24'd0, cmd});
        cur_half = int'(half);
        cur_max  = int'(att);
    endtask

    // Drives one whole read tick by tick; the response byte of each attempt is placed on
    // MISO at the rising ticks of the response bits, and other ticks carry noise.
    task automatic read_byte_at(input logic [7:0] addr, input int odd_pct);
        int         heff;
        int         lim;
        int         att;
        int         t;
        int         k;
        logic [7:0] rx_byte;
        bit         miso;
        heff = (cur_half == 0) ? 1 : cur_half;
        lim  = (cur_max == 0) ? 1 : cur_max;
        att  = 0;
        gap_on = ($urandom_range(0, 3) != 0);
        do begin
            att++;
            if (byte_plan.size() > 0) begin
                rx_byte = byte_plan.pop_front();
            end else begin
                rx_byte = byte_with_parity($urandom_range(0, 99) < odd_pct);
            end
            for (t = 0; t < 48 * heff; t++) begin
                k = t / (2 * heff) - 16;
                if (k >= 0 && (t % (2 * heff)) == 0) begin
                    miso = rx_byte[7 - k];
                end else begin
                    miso = 1'($urandom_range(0, 1));
                end
                if (att == 1 && t == 0) begin
                    send_tick(1'b1, addr, miso);
                end else begin
                    send_tick($urandom_range(0, 15) == 0, 8'($urandom), miso);
                end
            end
        end while ((^rx_byte) && att < lim);
        repeat ($urandom_range(0, 4)) send_tick(1'b0, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        program_spi(16'd1, 4'd0, 8'h00);
        byte_plan.push_back(8'h00);
        read_byte_at(8'h00, 0);
        byte_plan.push_back(8'h01);
        read_byte_at(8'hFF, 0);

        program_spi(16'd0, 4'd15, 8'hFF);
        byte_plan.push_back(8'hFF);
        read_byte_at(8'h5A, 0);
        byte_plan.push_back(8'h80);
        byte_plan.push_back(8'hFE);
        repeat (13) byte_plan.push_back(byte_with_parity(1'b1));
        read_byte_at(8'hA5, 0);

        while (sent < 1600) begin
            case ($urandom_range(0, 9))
                0:       program_spi(16'd0, 4'($urandom_range(0, 15)), 8'($urandom));
                1, 2, 3,
                4, 5:    program_spi(16'd1, 4'($urandom_range(0, 15)), 8'($urandom));
                6, 7:    program_spi(16'd2, 4'($urandom_range(0, 15)), 8'($urandom));
                8:       program_spi(16'd3, 4'($urandom_range(0, 15)), 8'($urandom));
                default: program_spi(16'd4, 4'($urandom_range(0, 15)), 8'($urandom));
            endcase
            repeat ($urandom_range(1, 4)) begin
                read_byte_at(8'($urandom), $urandom_range(0, 3) * 25);
                if ($urandom_range(0, 3) == 0) begin
                    wait_all_ticks_back();
                end
            end
        end

        // The widest half period leaves the read unfinished; nothing is written after it.
        program_spi(16'hFFFF, 4'd5, 8'h55);
        gap_on = 1'b1;
        send_tick(1'b1, 8'($urandom), 1'b1);
        repeat (150) send_tick($urandom_range(0, 3) == 0, 8'($urandom),
                               1'($urandom_range(0, 1)));

        wait_all_ticks_back();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* spi_parity_read_master.f */
+incdir+hdl
hdl/spm_pkg.sv
hdl/spi_parity_read_master.sv
sim/spi_parity_read_master_checker.sv
sim/spi_parity_read_master_test.sv
